// File: sv/hlbs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and saturating log-domain helpers for the backward smoother
// no dependencies; used by hlbs_logadd, hmm_log_backward_smoother and the testbench

package hlbs_pkg;

  // sizes
  localparam int MAX_STATES   = 64;
  localparam int LOG_WIDTH    = 32;
  localparam int CORR_ENTRIES = 256;
  localparam int CORR_W       = 16;
  localparam int CORR_SHIFT   = 12;
  localparam int CORR_IDX_W   = $clog2(CORR_ENTRIES);
  localparam int STATE_W      = $clog2(MAX_STATES);
  localparam int COUNT_W      = 7;
  localparam int TRANS_DEPTH  = MAX_STATES * MAX_STATES;
  localparam int DIFF_DEPTH   = 2 * MAX_STATES;
  localparam int TRANS_AW     = $clog2(TRANS_DEPTH);
  localparam int DIFF_AW      = $clog2(DIFF_DEPTH);
  localparam int CNT_W        = $clog2(MAX_STATES + 1);
  localparam longint unsigned EXP_STEP_Q30 = 64'd1008687096;

  // item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POS  = 1'b1;

  typedef logic signed [LOG_WIDTH-1:0] log_t;
  typedef logic signed [LOG_WIDTH:0]   wide_t;
  typedef logic [CORR_ENTRIES-1:0][CORR_W-1:0] corr_table_t;

  localparam log_t LOG_MAX = {1'b0, {(LOG_WIDTH-1){1'b1}}};
  localparam log_t LOG_NEG = {1'b1, {(LOG_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SUM,
    ST_FIN
  } seq_state_e;

  // clamp a one-bit-wider value into the log range
  function automatic log_t sat_wide(wide_t v);
    log_t r;
    if (v[LOG_WIDTH] != v[LOG_WIDTH-1]) begin
      r = v[LOG_WIDTH] ? LOG_NEG : LOG_MAX;
    end else begin
      r = v[LOG_WIDTH-1:0];
    end
    return r;
  endfunction

  // product of probabilities: minus infinity absorbs
  function automatic log_t log_mul(log_t a, log_t b);
    log_t r;
    if (a == LOG_NEG || b == LOG_NEG) begin
      r = LOG_NEG;
    end else begin
      r = sat_wide(wide_t'(a) + wide_t'(b));
    end
    return r;
  endfunction

  // ratio smooth / pred, minus infinity only from the numerator
  function automatic log_t log_div(log_t a, log_t b);
    log_t r;
    if (a == LOG_NEG) begin
      r = LOG_NEG;
    end else begin
      r = sat_wide(wide_t'(a) - wide_t'(b));
    end
    return r;
  endfunction

  // long division by shift and subtract, only used while the table is built
  function automatic longint unsigned shift_sub_div(longint unsigned num,
                                                    longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // correction table ln(1 + e^(-k/16)) in Q16, built at elaboration
  function automatic corr_table_t build_corr_table();
    longint unsigned y;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned s;
    corr_table_t tbl;
    y = 64'd1 << 30;
    for (int k = 0; k < CORR_ENTRIES; k++) begin
      z = shift_sub_div(y << 30, (64'd1 << 31) + y);
      z2 = (z * z) >> 30;
      t = z;
      s = 64'd0;
      for (int m = 1; m <= 29; m += 2) begin
        s = s + shift_sub_div(t, 64'(m));
        t = (t * z2) >> 30;
      end
      tbl[k] = CORR_W'((64'd2 * s + (64'd1 << 13)) >> 14);
      y = (y * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
    end
    return tbl;
  endfunction

  localparam corr_table_t CORR_TABLE = build_corr_table();

endpackage

// File: sv/hlbs_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module hlbs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/hlbs_logadd.sv
`timescale 1ns / 1ps
// shared log-add unit: max of two log values plus table correction
// depends on hlbs_pkg (types, correction table, saturation)

module hlbs_logadd (
  input  hlbs_pkg::log_t a_i,
  input  hlbs_pkg::log_t b_i,
  output hlbs_pkg::log_t y_o
);

  localparam int IdxFullW = hlbs_pkg::LOG_WIDTH - hlbs_pkg::CORR_SHIFT;

  hlbs_pkg::log_t                  hi;
  hlbs_pkg::log_t                  lo;
  logic [hlbs_pkg::LOG_WIDTH-1:0]  gap;
  logic [IdxFullW-1:0]             idx_full;
  logic [hlbs_pkg::CORR_W-1:0]     corr;
  hlbs_pkg::log_t                  sum_sat;

  // order the operands, distance is never negative
  always_comb begin
    if (a_i > b_i) begin
      hi = a_i;
      lo = b_i;
    end else begin
      hi = b_i;
      lo = a_i;
    end
    gap      = hi - lo;
    idx_full = gap[hlbs_pkg::LOG_WIDTH-1:hlbs_pkg::CORR_SHIFT];
  end

  // correction lookup, zero once the gap runs off the table
  always_comb begin
    if (idx_full < IdxFullW'(hlbs_pkg::CORR_ENTRIES)) begin
      corr = hlbs_pkg::CORR_TABLE[idx_full[hlbs_pkg::CORR_IDX_W-1:0]];
    end else begin
      corr = '0;
    end
    sum_sat = hlbs_pkg::sat_wide(hlbs_pkg::wide_t'(hi) +
                                 hlbs_pkg::wide_t'({1'b0, corr}));
  end

  // minus infinity is the identity
  always_comb begin
    if (a_i == hlbs_pkg::LOG_NEG) begin
      y_o = b_i;
    end else if (b_i == hlbs_pkg::LOG_NEG) begin
      y_o = a_i;
    end else begin
      y_o = sum_sat;
    end
  end

endmodule

// File: sv/hmm_log_backward_smoother.sv
`timescale 1ns / 1ps
// top level of the log-domain backward smoother: stream ports, sequencer, stores
// depends on hlbs_pkg, hlbs_ram, hlbs_logadd
//
//  port group  dir  fields (lowest bit up)
//  s_axis      in   tdata: from_state, to_state, trans_log, state, filt_log, pred_log
//                   tuser: op, first_position; tlast: last_state
//  m_axis      out  tdata: smooth_log, out_state; tlast: position_done
//  cfg         in   cfg_we_i / cfg_wdata_i: state_count
//
// transition load items can follow back to back. a first-position item copies its
// filtered value to the final step; any other position item sums terms over
// n = min(state_count, 64) next states, one pass of the shared log-add unit each.
// reset clears the sequencer, bank select and output valid, and sets state_count to 8;
// the stores are not cleared. a result waiting on m_axis stalls only the final step of
// the following position item.

module hmm_log_backward_smoother (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // from_state[5:0], to_state[11:6], trans_log[43:12], state[49:44],
  // filt_log[81:50], pred_log[113:82], zero pad[119:114]
  input  logic [119:0] s_axis_tdata,
  // op[0], first_position[1]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // smooth_log[31:0], out_state[37:32], zero pad[39:38]
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int LW = hlbs_pkg::LOG_WIDTH;
  localparam int SW = hlbs_pkg::STATE_W;
  localparam int CW = hlbs_pkg::CNT_W;

  // input field unpacking
  logic [SW-1:0]   in_from;
  logic [SW-1:0]   in_to;
  hlbs_pkg::log_t  in_trans;
  logic [SW-1:0]   in_state;
  hlbs_pkg::log_t  in_filt;
  hlbs_pkg::log_t  in_pred;
  logic            in_op;
  logic            in_first;

  assign in_from  = s_axis_tdata[SW-1:0];
  assign in_to    = s_axis_tdata[2*SW-1:SW];
  assign in_trans = s_axis_tdata[2*SW+LW-1:2*SW];
  assign in_state = s_axis_tdata[3*SW+LW-1:2*SW+LW];
  assign in_filt  = s_axis_tdata[3*SW+2*LW-1:3*SW+LW];
  assign in_pred  = s_axis_tdata[3*SW+3*LW-1:3*SW+2*LW];
  assign in_op    = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];

  // registers
  hlbs_pkg::seq_state_e             state_q, state_d;
  logic [hlbs_pkg::COUNT_W-1:0]     count_q;
  logic                             bank_q;
  logic [CW-1:0]                    cnt_q;
  logic                             rd_v_q;
  logic                             term_v_q;
  hlbs_pkg::log_t                   term_q;
  hlbs_pkg::log_t                   acc_q;
  hlbs_pkg::log_t                   smooth_q;
  hlbs_pkg::log_t                   filt_q;
  hlbs_pkg::log_t                   pred_q;
  logic [SW-1:0]                    pos_state_q;
  logic                             last_q;
  logic                             m_valid_q;
  hlbs_pkg::log_t                   m_smooth_q;
  logic [SW-1:0]                    m_state_q;
  logic                             m_last_q;

  // control
  logic            s_fire;
  logic            load_we;
  logic            start_run;
  logic            start_copy;
  logic            issue;
  logic            run_done;
  logic            fin_go;
  logic [CW-1:0]   count_eff;

  hlbs_pkg::log_t  trans_rd;
  hlbs_pkg::log_t  diff_rd;
  hlbs_pkg::log_t  acc_next;
  hlbs_pkg::log_t  diff_wr;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign load_we    = s_fire && (in_op == hlbs_pkg::OP_LOAD);
  assign start_run  = s_fire && (in_op == hlbs_pkg::OP_POS) && !in_first;
  assign start_copy = s_fire && (in_op == hlbs_pkg::OP_POS) && in_first;

  // effective number of next states in the sum
  assign count_eff = (count_q > hlbs_pkg::COUNT_W'(hlbs_pkg::MAX_STATES))
                     ? CW'(hlbs_pkg::MAX_STATES) : CW'(count_q);

  assign run_done = (cnt_q == count_eff) && !rd_v_q && !term_v_q;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hlbs_pkg::ST_IDLE: begin
        if (start_run) begin
          state_d = hlbs_pkg::ST_RUN;
        end else if (start_copy) begin
          state_d = hlbs_pkg::ST_FIN;
        end
      end
      hlbs_pkg::ST_RUN: begin
        if (run_done) begin
          state_d = hlbs_pkg::ST_SUM;
        end
      end
      hlbs_pkg::ST_SUM: begin
        state_d = hlbs_pkg::ST_FIN;
      end
      hlbs_pkg::ST_FIN: begin
        if (fin_go) begin
          state_d = hlbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hlbs_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    fin_go        = 1'b0;
    unique case (state_q)
      hlbs_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      hlbs_pkg::ST_RUN: begin
        issue = (cnt_q < count_eff);
      end
      hlbs_pkg::ST_SUM: begin
        issue = 1'b0;
      end
      hlbs_pkg::ST_FIN: begin
        fin_go = !m_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= hlbs_pkg::COUNT_W'(8);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // transition store, row = state, column = next state
  hlbs_ram #(
    .DEPTH (hlbs_pkg::TRANS_DEPTH),
    .WIDTH (LW)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i ({in_from, in_to}),
    .wdata_i (in_trans),
    .raddr_i ({pos_state_q, cnt_q[SW-1:0]}),
    .rdata_o (trans_rd)
  );

  // difference banks: write current bank, read the other
  hlbs_ram #(
    .DEPTH (hlbs_pkg::DIFF_DEPTH),
    .WIDTH (LW)
  ) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    (fin_go),
    .waddr_i ({bank_q, pos_state_q}),
    .wdata_i (diff_wr),
    .raddr_i ({~bank_q, cnt_q[SW-1:0]}),
    .rdata_o (diff_rd)
  );

  // shared log-add unit folds one term per cycle into the accumulator
  hlbs_logadd u_logadd (
    .a_i (acc_q),
    .b_i (term_q),
    .y_o (acc_next)
  );

  assign diff_wr = hlbs_pkg::log_div(smooth_q, pred_q);

  // read issue counter and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_v_q   <= 1'b0;
      term_v_q <= 1'b0;
    end else begin
      rd_v_q   <= issue;
      term_v_q <= rd_v_q;
      if (start_run) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // item capture, term, accumulator and smoothed value
  always_ff @(posedge clk_i) begin
    if (s_fire && (in_op == hlbs_pkg::OP_POS)) begin
      pos_state_q <= in_state;
      filt_q      <= in_filt;
      pred_q      <= in_pred;
      last_q      <= s_axis_tlast;
    end
    if (start_copy) begin
      smooth_q <= in_filt;
    end else if (state_q == hlbs_pkg::ST_SUM) begin
      smooth_q <= hlbs_pkg::log_mul(filt_q, acc_q);
    end
    if (rd_v_q) begin
      term_q <= hlbs_pkg::log_mul(trans_rd, diff_rd);
    end
    if (start_run) begin
      acc_q <= hlbs_pkg::LOG_NEG;
    end else if (term_v_q) begin
      acc_q <= acc_next;
    end
  end

  // bank select flips after the final state of a position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
    end else if (fin_go && last_q) begin
      bank_q <= ~bank_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      m_smooth_q <= smooth_q;
      m_state_q  <= pos_state_q;
      m_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_state_q, m_smooth_q};
  assign m_axis_tlast  = m_last_q;

  // pipeline is drained before the final sum is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hlbs_pkg::ST_SUM) |-> (!rd_v_q && !term_v_q))
    else $error("log-sum pipeline not empty at final sum");

  // never more reads than next states in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hlbs_pkg::ST_RUN) |-> (cnt_q <= count_eff))
    else $error("read counter ran past state count");

  // a result only replaces an empty or departing output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |-> (!m_valid_q || m_axis_tready))
    else $error("result overwrote a waiting item");

  // bank flips exactly when the last state of a position completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && last_q) |=> (bank_q != $past(bank_q)))
    else $error("bank select did not flip at end of position");

endmodule

// File: tb/tb_hmm_log_backward_smoother.sv
`timescale 1ns / 1ps
// self-checking testbench for hmm_log_backward_smoother: stream driver, result monitor, predictor
// depends on hlbs_pkg (types, op codes) and the hmm_log_backward_smoother top level

module tb_hmm_log_backward_smoother;

  typedef hlbs_pkg::log_t log_t;

  localparam log_t LOG_MAX = hlbs_pkg::LOG_MAX;
  localparam log_t LOG_NEG = hlbs_pkg::LOG_NEG;
  localparam logic OP_LOAD = hlbs_pkg::OP_LOAD;
  localparam logic OP_POS = hlbs_pkg::OP_POS;

  localparam longint unsigned EXP_Q30 = 64'd1008687096;
  localparam int LUT_SIZE = 256;
  localparam int LUT_SHIFT = 12;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS = 900;
  localparam longint TIMEOUT_NS = 64'd40_000_000;

  // one input item, all fields present whatever the kind
  typedef struct {
    logic       kind;
    logic [5:0] row;
    logic [5:0] col;
    log_t       trans;
    logic [5:0] st;
    log_t       filt;
    log_t       pred;
    logic       first;
    logic       last;
  } smoother_item_t;

  // one smoothed result
  typedef struct {
    log_t       smooth;
    logic [5:0] st;
    logic       done;
  } smoothed_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [6:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;

  hmm_log_backward_smoother DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // predictor state
  logic [15:0] corr_lut [0:LUT_SIZE-1];
  log_t        trans_mem [0:4095];
  log_t        diff_mem [0:1][0:63];
  bit          model_bank = 1'b0;
  logic [6:0]  model_count = 7'd8;
  smoothed_t   smoothed_q[$];

  // stimulus bookkeeping: which store entries have been written so far
  bit             gen_trans_ok [0:4095];
  bit             gen_diff_ok [0:1][0:63];
  bit             gen_bank = 1'b0;
  int             gen_n = 8;
  smoother_item_t pending_q[$];

  int items_sent = 0;
  int items_taken = 0;
  int loads_made = 0;
  int positions_made = 0;
  int results_seen = 0;
  int config_writes = 0;
  int errors = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ln(1 + e^(-k/16)) in Q16 from an atanh series, integers only
  function automatic void fill_corr_lut();
    longint unsigned y;
    longint unsigned z;
    longint unsigned zsq;
    longint unsigned term;
    longint unsigned acc;
    y = 64'd1 << 30;
    for (int k = 0; k < LUT_SIZE; k++) begin
      z = (y << 30) / ((64'd1 << 31) + y);
      zsq = (z * z) >> 30;
      term = z;
      acc = 64'd0;
      for (int m = 1; m <= 29; m += 2) begin
        acc = acc + term / 64'(m);
        term = (term * zsq) >> 30;
      end
      corr_lut[k] = 16'((64'd2 * acc + (64'd1 << 13)) >> 14);
      y = (y * EXP_Q30 + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic log_t clamp_log(longint v);
    log_t r;
    if (v > longint'(LOG_MAX)) begin
      r = LOG_MAX;
    end else if (v < longint'(LOG_NEG)) begin
      r = LOG_NEG;
    end else begin
      r = log_t'(v);
    end
    return r;
  endfunction

  // product of probabilities, minus infinity absorbs
  function automatic log_t prob_mul(log_t a, log_t b);
    log_t r;
    if (a == LOG_NEG || b == LOG_NEG) begin
      r = LOG_NEG;
    end else begin
      r = clamp_log(longint'(a) + longint'(b));
    end
    return r;
  endfunction

  // sum of probabilities: max plus table correction
  function automatic log_t log_plus(log_t a, log_t b);
    log_t hi;
    log_t lo;
    longint gap;
    log_t r;
    if (a == LOG_NEG) begin
      r = b;
    end else if (b == LOG_NEG) begin
      r = a;
    end else begin
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      gap = longint'(hi) - longint'(lo);
      if ((gap >> LUT_SHIFT) < LUT_SIZE) begin
        r = clamp_log(longint'(hi) + longint'(corr_lut[gap >> LUT_SHIFT]));
      end else begin
        r = hi;
      end
    end
    return r;
  endfunction

  // apply one accepted item to the predictor, queue the smoothed value it yields
  task automatic smooth_step(smoother_item_t it);
    int n;
    log_t acc;
    log_t smooth;
    log_t dlt;
    smoothed_t res;
    if (it.kind == OP_LOAD) begin
      trans_mem[{it.row, it.col}] = it.trans;
    end else begin
      n = (model_count < 7'd64) ? int'(model_count) : 64;
      if (it.first) begin
        smooth = it.filt;
      end else begin
        acc = LOG_NEG;
        for (int j = 0; j < n; j++) begin
          acc = log_plus(acc, prob_mul(trans_mem[{it.st, 6'(j)}], diff_mem[model_bank ^ 1'b1][j]));
        end
        smooth = prob_mul(it.filt, acc);
      end
      dlt = (smooth == LOG_NEG) ? LOG_NEG : clamp_log(longint'(smooth) - longint'(it.pred));
      diff_mem[model_bank][it.st] = dlt;
      if (it.last) begin
        model_bank = model_bank ^ 1'b1;
      end
      res.smooth = smooth;
      res.st = it.st;
      res.done = it.last;
      smoothed_q.push_back(res);
    end
  endtask

  // mostly realistic log values, with the extremes and minus infinity mixed in
  function automatic log_t rand_log();
    log_t v;
    case ($urandom_range(0, 19))
      0: v = LOG_NEG;
      1: v = LOG_MAX;
      2, 3: v = log_t'($urandom);
      4: v = log_t'($urandom_range(0, 32'h0004_0000));
      default: v = log_t'(-longint'($urandom_range(0, 32'h0018_0000)));
    endcase
    return v;
  endfunction

  task automatic push_load(int row, int col, log_t val);
    smoother_item_t it;
    it.kind = OP_LOAD;
    it.row = 6'(row);
    it.col = 6'(col);
    it.trans = val;
    it.st = 6'($urandom);
    it.filt = log_t'($urandom);
    it.pred = log_t'($urandom);
    it.first = 1'($urandom);
    it.last = 1'($urandom);
    gen_trans_ok[{it.row, it.col}] = 1'b1;
    pending_q.push_back(it);
    items_sent++;
    loads_made++;
  endtask

  // position item; falls back to a first position when the previous differences are
  // incomplete, and otherwise loads any missing transition entry of its row below the count
  task automatic push_pos(int st, log_t filt, log_t pred, logic first, logic closing);
    smoother_item_t it;
    logic use_copy;
    use_copy = first;
    if (!use_copy) begin
      for (int j = 0; j < gen_n; j++) begin
        if (!gen_diff_ok[gen_bank ^ 1'b1][j]) begin
          use_copy = 1'b1;
        end
      end
    end
    if (!use_copy) begin
      for (int j = 0; j < gen_n; j++) begin
        if (!gen_trans_ok[{6'(st), 6'(j)}]) begin
          push_load(st, j, rand_log());
        end
      end
    end
    it.kind = OP_POS;
    it.row = 6'($urandom);
    it.col = 6'($urandom);
    it.trans = log_t'($urandom);
    it.st = 6'(st);
    it.filt = filt;
    it.pred = pred;
    it.first = use_copy;
    it.last = closing;
    gen_diff_ok[gen_bank][st] = 1'b1;
    if (closing) begin
      gen_bank = gen_bank ^ 1'b1;
    end
    pending_q.push_back(it);
    items_sent++;
    positions_made++;
  endtask

  // one chain of positions at the current state count, with some noise and broken positions
  task automatic gen_chain();
    int order[$];
    int n_pos;
    int pick;
    int tmp;
    logic first;
    logic closing;
    n_pos = (gen_n == 64) ? 2 : $urandom_range(3, 7);
    for (int p = 0; p < n_pos; p++) begin
      order.delete();
      if (gen_n == 64 && p > 0) begin
        // full rows are costly at the top count, so only a few states here
        for (int i = 0; i < 3; i++) begin
          order.push_back($urandom_range(0, 63));
        end
      end else begin
        for (int i = 0; i < gen_n; i++) begin
          order.push_back(i);
        end
        for (int i = gen_n - 1; i > 0; i--) begin
          pick = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[pick];
          order[pick] = tmp;
        end
      end
      // a state beyond the count
      if (gen_n < 64 && $urandom_range(0, 3) == 0) begin
        order.insert($urandom_range(0, order.size()), $urandom_range(gen_n, 63));
      end
      // broken position: one state missing
      if (p > 0 && order.size() > 1 && $urandom_range(0, 9) == 0) begin
        order.delete($urandom_range(0, order.size() - 1));
      end
      // stray transition rewrite
      if ($urandom_range(0, 11) == 0) begin
        push_load($urandom_range(0, 63), $urandom_range(0, 63), rand_log());
      end
      for (int i = 0; i < order.size(); i++) begin
        first = (p == 0) || ($urandom_range(0, 14) == 0);
        closing = (i == order.size() - 1) && !(p < n_pos - 1 && $urandom_range(0, 19) == 0);
        push_pos(order[i], rand_log(), rand_log(), first, closing);
      end
    end
  endtask

  // register write while nothing is in flight
  task automatic set_state_count(int v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_count = 7'(v);
    gen_n = (v < 64) ? v : 64;
    config_writes++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_sent || smoothed_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // sender: bursts of random length with random gaps
  smoother_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        smooth_step(cur_item);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, cur_item.pred, cur_item.filt, cur_item.st, cur_item.trans,
                           cur_item.col, cur_item.row};
          s_axis_tuser <= {cur_item.first, cur_item.kind};
          s_axis_tlast <= cur_item.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: alternating ready and stall runs, mostly short stalls, now and then a long one
  bit rdy_level = 1'b0;
  int rdy_left = 0;
  smoothed_t want;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (smoothed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got smooth %h state %0d done %b",
                 $time, m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast);
      end else begin
        want = smoothed_q.pop_front();
        if (m_axis_tdata[31:0] !== want.smooth) begin
          errors++;
          $display("%0t: smooth_log mismatch, expected %h got %h", $time, want.smooth,
                   m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[37:32] !== want.st) begin
          errors++;
          $display("%0t: out_state mismatch, expected %0d got %0d", $time, want.st,
                   m_axis_tdata[37:32]);
        end
        if (m_axis_tlast !== want.done) begin
          errors++;
          $display("%0t: position_done mismatch, expected %b got %b", $time, want.done,
                   m_axis_tlast);
        end
      end
    end
    if (rdy_left <= 0) begin
      rdy_level = ~rdy_level;
      if (rdy_level) begin
        rdy_left = $urandom_range(1, 40);
      end else begin
        rdy_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 3);
      end
    end
    rdy_left--;
    m_axis_tready <= rdy_level;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("hmm_log_backward_smoother test failed");
    $finish;
  end

  // main sequence
  initial begin
    int n_set;
    int phase_no;
    fill_corr_lut();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: two states, extremes of every field
    set_state_count(2);
    push_load(0, 0, LOG_NEG);
    push_load(0, 1, LOG_MAX);
    push_load(1, 0, 0);
    push_load(1, 1, -1);
    push_load(63, 0, 32'sh0000_8000);
    push_load(63, 1, -32'sd196608);
    // first position copies, saturated and minus infinity differences, state beyond count
    push_pos(0, LOG_MAX, LOG_NEG, 1'b1, 1'b0);
    push_pos(63, 0, LOG_MAX, 1'b1, 1'b0);
    push_pos(1, LOG_NEG, 0, 1'b1, 1'b1);
    // all terms minus infinity, saturating sums, state beyond count
    push_pos(0, -32'sd65536, 0, 1'b0, 1'b0);
    push_pos(1, LOG_MAX, LOG_NEG, 1'b0, 1'b0);
    push_pos(63, LOG_NEG, -32'sd65536, 1'b0, 1'b1);
    // restart with large differences so the log-add itself saturates
    push_pos(1, LOG_MAX, 0, 1'b1, 1'b0);
    push_pos(0, LOG_MAX, 0, 1'b1, 1'b1);
    push_pos(1, -1, -32'sd131072, 1'b0, 1'b0);
    push_pos(0, 32'sh0001_0000, 32'sh7000_0000, 1'b0, 1'b1);
    wait_drained();

    // random chains over a spread of state counts
    phase_no = 0;
    while (items_sent < RANDOM_ITEMS + 16) begin
      case (phase_no % 5)
        0: n_set = 64;
        1: n_set = 2;
        2: n_set = $urandom_range(3, 8);
        3: n_set = $urandom_range(2, 16);
        default: n_set = $urandom_range(9, 16);
      endcase
      set_state_count(n_set);
      gen_chain();
      wait_drained();
      phase_no++;
    end

    if (smoothed_q.size() != 0) begin
      errors++;
      $display("%0t: %0d smoothed results never arrived, expected state %0d got none",
               $time, smoothed_q.size(), smoothed_q[0].st);
    end
    $display("covered %0d transition loads and %0d position items under %0d state_count writes",
             loads_made, positions_made, config_writes);
    $display("%0d smoothed results compared, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("hmm_log_backward_smoother test passed");
    end else begin
      $display("hmm_log_backward_smoother test failed");
    end
    $finish;
  end

endmodule
